// ----- rtl/block_average_downscale_threshold_top_defines.svh -----
// Assertion macros shared by the downscale RTL
`ifndef BLOCK_AVERAGE_DOWNSCALE_THRESHOLD_TOP_DEFINES_SVH
`define BLOCK_AVERAGE_DOWNSCALE_THRESHOLD_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define BADS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bads: assertion failed");

// Consequent checked in the cycle after the antecedent
`define BADS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bads: assertion failed");

`endif

// ----- rtl/bads_pkg.sv -----
// Shared constants and types for the block-average downscale
package bads_pkg;

  localparam int GRID_SIZE_DEF   = 28;
  localparam int MAX_DIM_DEF     = 1024;
  localparam int PIXEL_BITS_DEF  = 8;

  localparam int CFG_DATA_W      = 11;
  localparam int CFG_INDEX_W     = 2;

  localparam int IMAGE_WIDTH_RST  = 640;
  localparam int IMAGE_HEIGHT_RST = 438;

  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic blk_end;
    logic last;
  } cell_ctrl_t;

  localparam int CTRL_W = $bits(cell_ctrl_t);

endpackage

// ----- rtl/bads_queue.sv -----
// Short FIFO between the classifying front and the accumulating back
`include "block_average_downscale_threshold_top_defines.svh"

module bads_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = bads_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `BADS_ASSERT_IMPL(q_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `BADS_ASSERT_IMPL(q_no_underflow, clk_i, rst_ni, pop_i, valid_o)
  `BADS_ASSERT_NEXT(q_count_grows, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + CNT_W'(1))

endmodule

// ----- rtl/bads_front.sv -----
// Front end: size registers, raster position tracking and pixel classification
`include "block_average_downscale_threshold_top_defines.svh"

module bads_front #(
  parameter int GRID_SIZE  = bads_pkg::GRID_SIZE_DEF,
  parameter int MAX_DIM    = bads_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = bads_pkg::PIXEL_BITS_DEF,
  localparam int IDX_W     = $clog2(GRID_SIZE),
  localparam int BLK_W     = $clog2(MAX_DIM / GRID_SIZE + 1),
  localparam int ENTRY_W   = PIXEL_BITS + 2 * IDX_W + bads_pkg::CTRL_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bads_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [bads_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               pixel_valid_i,
  output logic                               pixel_stall_o,
  input  logic [PIXEL_BITS-1:0]              pixel_i,
  input  logic                               q_full_i,
  output logic                               push_o,
  output logic [ENTRY_W-1:0]                 entry_o,
  output logic                               restart_o,
  output logic [2*BLK_W-1:0]                 area_o
);

  localparam int GC_W   = $clog2(GRID_SIZE + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int EXT_W  = (DIM_W > bads_pkg::CFG_DATA_W) ? DIM_W : bads_pkg::CFG_DATA_W;
  localparam int SHIFT  = DIM_W + $clog2(GRID_SIZE);
  localparam int RECIP  = ((1 << SHIFT) + GRID_SIZE - 1) / GRID_SIZE;
  localparam int PROD_W = 2 * DIM_W + 1;
  localparam int RST_W  = (bads_pkg::IMAGE_WIDTH_RST < GRID_SIZE) ? GRID_SIZE :
                          (bads_pkg::IMAGE_WIDTH_RST > MAX_DIM) ? MAX_DIM :
                          bads_pkg::IMAGE_WIDTH_RST;
  localparam int RST_H  = (bads_pkg::IMAGE_HEIGHT_RST < GRID_SIZE) ? GRID_SIZE :
                          (bads_pkg::IMAGE_HEIGHT_RST > MAX_DIM) ? MAX_DIM :
                          bads_pkg::IMAGE_HEIGHT_RST;
  localparam int RST_BW = RST_W / GRID_SIZE;
  localparam int RST_BH = RST_H / GRID_SIZE;

  // Clamp a written dimension into the supported range
  function automatic logic [DIM_W-1:0] eff_dim(input logic [bads_pkg::CFG_DATA_W-1:0] v);
    logic [EXT_W-1:0] x;
    x = EXT_W'(v);
    if (x < EXT_W'(GRID_SIZE)) begin
      x = EXT_W'(GRID_SIZE);
    end else if (x > EXT_W'(MAX_DIM)) begin
      x = EXT_W'(MAX_DIM);
    end
    return DIM_W'(x);
  endfunction

  // Divide by the grid size through a reciprocal multiply, exact over the dimension range
  function automatic logic [BLK_W-1:0] block_dim(input logic [DIM_W-1:0] d);
    logic [PROD_W-1:0] p;
    p = PROD_W'(d) * PROD_W'(RECIP);
    return p[SHIFT +: BLK_W];
  endfunction

  logic [DIM_W-1:0]   w_q, h_q;
  logic [BLK_W-1:0]   bw_q, bh_q;
  logic [2*BLK_W-1:0] area_q;
  logic [DIM_W-1:0]   cfg_dim;
  logic [BLK_W-1:0]   cfg_blk;

  logic [DIM_W-1:0]   pixel_x_q, pixel_x_d, pixel_y_q, pixel_y_d;
  logic [BLK_W-1:0]   in_blk_x_q, in_blk_x_d, in_blk_y_q, in_blk_y_d;
  logic [GC_W-1:0]    grid_col_q, grid_col_d, grid_row_q, grid_row_d;

  logic               accept, in_grid, x_wrap, y_wrap, blk_x_end, blk_y_end;
  bads_pkg::cell_ctrl_t ctrl;

  assign cfg_ready_o = 1'b1;
  assign cfg_dim     = eff_dim(cfg_data_i);
  assign cfg_blk     = block_dim(cfg_dim);
  assign restart_o   = cfg_valid_i &&
                       (cfg_index_i == bads_pkg::REG_IMAGE_WIDTH ||
                        cfg_index_i == bads_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= DIM_W'(RST_W);
      h_q  <= DIM_W'(RST_H);
      bw_q <= BLK_W'(RST_BW);
      bh_q <= BLK_W'(RST_BH);
    end else if (cfg_valid_i) begin
      unique case (bads_pkg::cfg_reg_e'(cfg_index_i))
        bads_pkg::REG_IMAGE_WIDTH: begin
          w_q  <= cfg_dim;
          bw_q <= cfg_blk;
        end
        bads_pkg::REG_IMAGE_HEIGHT: begin
          h_q  <= cfg_dim;
          bh_q <= cfg_blk;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= (2*BLK_W)'(RST_BW * RST_BH);
    end else begin
      area_q <= (2*BLK_W)'(bw_q) * (2*BLK_W)'(bh_q);
    end
  end

  assign area_o = area_q;

  assign pixel_stall_o = q_full_i;
  assign accept        = pixel_valid_i && !q_full_i;
  assign in_grid       = (grid_col_q < GC_W'(GRID_SIZE)) && (grid_row_q < GC_W'(GRID_SIZE));
  assign x_wrap        = (pixel_x_q == w_q - DIM_W'(1));
  assign y_wrap        = (pixel_y_q == h_q - DIM_W'(1));
  assign blk_x_end     = (in_blk_x_q == bw_q - BLK_W'(1));
  assign blk_y_end     = (in_blk_y_q == bh_q - BLK_W'(1));

  always_comb begin
    pixel_x_d  = pixel_x_q;
    pixel_y_d  = pixel_y_q;
    in_blk_x_d = in_blk_x_q;
    in_blk_y_d = in_blk_y_q;
    grid_col_d = grid_col_q;
    grid_row_d = grid_row_q;
    if (restart_o) begin
      pixel_x_d  = '0;
      pixel_y_d  = '0;
      in_blk_x_d = '0;
      in_blk_y_d = '0;
      grid_col_d = '0;
      grid_row_d = '0;
    end else if (accept) begin
      if (x_wrap) begin
        pixel_x_d  = '0;
        in_blk_x_d = '0;
        grid_col_d = '0;
        if (y_wrap) begin
          pixel_y_d  = '0;
          in_blk_y_d = '0;
          grid_row_d = '0;
        end else begin
          pixel_y_d = pixel_y_q + DIM_W'(1);
          if (blk_y_end) begin
            in_blk_y_d = '0;
            // saturate once past the last grid row
            if (grid_row_q < GC_W'(GRID_SIZE)) grid_row_d = grid_row_q + GC_W'(1);
          end else begin
            in_blk_y_d = in_blk_y_q + BLK_W'(1);
          end
        end
      end else begin
        pixel_x_d = pixel_x_q + DIM_W'(1);
        if (blk_x_end) begin
          in_blk_x_d = '0;
          if (grid_col_q < GC_W'(GRID_SIZE)) grid_col_d = grid_col_q + GC_W'(1);
        end else begin
          in_blk_x_d = in_blk_x_q + BLK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_x_q  <= '0;
      pixel_y_q  <= '0;
      in_blk_x_q <= '0;
      in_blk_y_q <= '0;
      grid_col_q <= '0;
      grid_row_q <= '0;
    end else begin
      pixel_x_q  <= pixel_x_d;
      pixel_y_q  <= pixel_y_d;
      in_blk_x_q <= in_blk_x_d;
      in_blk_y_q <= in_blk_y_d;
      grid_col_q <= grid_col_d;
      grid_row_q <= grid_row_d;
    end
  end

  // Drop pixels outside the used grid here; only in-grid pixels reach the back
  assign ctrl.blk_end = blk_x_end && blk_y_end;
  assign ctrl.last    = blk_x_end && blk_y_end &&
                        (grid_row_q == GC_W'(GRID_SIZE - 1)) &&
                        (grid_col_q == GC_W'(GRID_SIZE - 1));
  assign push_o  = accept && in_grid;
  assign entry_o = {ctrl, grid_row_q[IDX_W-1:0], grid_col_q[IDX_W-1:0], pixel_i};

  `BADS_ASSERT_NEXT(front_restart_clears, clk_i, rst_ni, restart_o, pixel_x_q == '0 && grid_row_q == '0 && grid_col_q == '0)

endmodule

// ----- rtl/bads_back.sv -----
// Back end: per-column block sums, threshold and output register
`include "block_average_downscale_threshold_top_defines.svh"

module bads_back #(
  parameter int GRID_SIZE  = bads_pkg::GRID_SIZE_DEF,
  parameter int MAX_DIM    = bads_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = bads_pkg::PIXEL_BITS_DEF,
  localparam int IDX_W     = $clog2(GRID_SIZE),
  localparam int BLK_W     = $clog2(MAX_DIM / GRID_SIZE + 1),
  localparam int ENTRY_W   = PIXEL_BITS + 2 * IDX_W + bads_pkg::CTRL_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic [2*BLK_W-1:0]   area_i,
  input  logic                 q_valid_i,
  input  logic [ENTRY_W-1:0]   q_data_i,
  output logic                 pop_o,
  output logic                 cell_valid_o,
  input  logic                 cell_stall_i,
  output logic                 cell_value_o,
  output logic [IDX_W-1:0]     cell_row_o,
  output logic [IDX_W-1:0]     cell_col_o,
  output logic                 last_cell_o
);

  localparam int SUM_W = 2 * BLK_W + PIXEL_BITS;

  logic [SUM_W-1:0]      sums_q [GRID_SIZE];
  logic [PIXEL_BITS-1:0] pix;
  logic [IDX_W-1:0]      col, row;
  bads_pkg::cell_ctrl_t  ctrl;
  logic [SUM_W-1:0]      new_sum;
  logic [SUM_W:0]        sum2;
  logic                  load;

  logic                  cell_valid_q;
  logic                  cell_value_q, last_cell_q;
  logic [IDX_W-1:0]      cell_row_q, cell_col_q;

  assign pix  = q_data_i[PIXEL_BITS-1:0];
  assign col  = q_data_i[PIXEL_BITS +: IDX_W];
  assign row  = q_data_i[PIXEL_BITS + IDX_W +: IDX_W];
  assign ctrl = bads_pkg::cell_ctrl_t'(q_data_i[ENTRY_W-1 -: bads_pkg::CTRL_W]);

  // Inner pixels never wait; a finished block waits for a free output slot
  assign pop_o = q_valid_i && (!ctrl.blk_end || !cell_valid_q || !cell_stall_i);
  assign load  = pop_o && ctrl.blk_end;

  assign new_sum = sums_q[col] + SUM_W'(pix);
  assign sum2    = {new_sum, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GRID_SIZE; i++) sums_q[i] <= '0;
    end else if (restart_i) begin
      for (int i = 0; i < GRID_SIZE; i++) sums_q[i] <= '0;
    end else if (pop_o) begin
      sums_q[col] <= ctrl.blk_end ? '0 : new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= 1'b0;
    end else if (load) begin
      cell_valid_q <= 1'b1;
    end else if (!cell_stall_i) begin
      cell_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cell_value_q <= (sum2 >= (SUM_W+1)'(area_i));
      cell_row_q   <= row;
      cell_col_q   <= col;
      last_cell_q  <= ctrl.last;
    end
  end

  assign cell_valid_o = cell_valid_q;
  assign cell_value_o = cell_value_q;
  assign cell_row_o   = cell_row_q;
  assign cell_col_o   = cell_col_q;
  assign last_cell_o  = last_cell_q;

  `BADS_ASSERT_IMPL(back_cell_from_pop, clk_i, rst_ni, $rose(cell_valid_q), $past(load))
  `BADS_ASSERT_NEXT(back_restart_clears, clk_i, rst_ni, restart_i, sums_q[0] == '0)

endmodule

// ----- rtl/block_average_downscale_threshold_top.sv -----
// Top level of the block-average downscale to a binary grid
// Throughput: one pixel per cycle unless stalled; one column-sum update per pixel.
// A block's last pixel is queued; the back end registers its cell when it pops it.
// Reset: asynchronous, active low; size registers return to 640 by 438, position
// counters, column sums, queue and output valid flag clear at once.
module block_average_downscale_threshold_top #(
  parameter int GRID_SIZE  = bads_pkg::GRID_SIZE_DEF,
  parameter int MAX_DIM    = bads_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = bads_pkg::PIXEL_BITS_DEF,
  localparam int IDX_W     = $clog2(GRID_SIZE)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bads_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [bads_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             pixel_valid_i,
  output logic                             pixel_stall_o,
  input  logic [PIXEL_BITS-1:0]            pixel_i,
  output logic                             cell_valid_o,
  input  logic                             cell_stall_i,
  output logic                             cell_value_o,
  output logic [IDX_W-1:0]                 cell_row_o,
  output logic [IDX_W-1:0]                 cell_col_o,
  output logic                             last_cell_o
);

  localparam int BLK_W   = $clog2(MAX_DIM / GRID_SIZE + 1);
  localparam int ENTRY_W = PIXEL_BITS + 2 * IDX_W + bads_pkg::CTRL_W;

  logic               q_full, q_push, q_pop, q_valid, restart;
  logic [ENTRY_W-1:0] push_data, head_data;
  logic [2*BLK_W-1:0] area;

  bads_front #(
    .GRID_SIZE  (GRID_SIZE),
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .pixel_i       (pixel_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .entry_o       (push_data),
    .restart_o     (restart),
    .area_o        (area)
  );

  bads_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (bads_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_data)
  );

  bads_back #(
    .GRID_SIZE  (GRID_SIZE),
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .area_i       (area),
    .q_valid_i    (q_valid),
    .q_data_i     (head_data),
    .pop_o        (q_pop),
    .cell_valid_o (cell_valid_o),
    .cell_stall_i (cell_stall_i),
    .cell_value_o (cell_value_o),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .last_cell_o  (last_cell_o)
  );

endmodule

// ----- verif/block_average_downscale_threshold_top_tb.sv -----
// Self-checking testbench for the block-average downscale to a 28 by 28 binary grid
`timescale 1ns / 1ps

module block_average_downscale_threshold_top_tb;

  localparam int GRID    = bads_pkg::GRID_SIZE_DEF;
  localparam int MAX_DIM = bads_pkg::MAX_DIM_DEF;
  localparam int DATA_W  = bads_pkg::CFG_DATA_W;
  localparam int INDEX_W = bads_pkg::CFG_INDEX_W;

  // indexes past the register map; writes to them must be ignored
  localparam logic [INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic       value;
    logic [4:0] row;
    logic [4:0] col;
    logic       is_last;
  } cell_t;

  class grid_cell_tracker;
    logic [DATA_W-1:0] width_reg;
    logic [DATA_W-1:0] height_reg;
    int unsigned       col_sum [GRID];
    int unsigned       px, py, bx, by, gcol, grow;
    cell_t             pending_cells [$];
    int                errors;

    function new();
      width_reg  = DATA_W'(bads_pkg::IMAGE_WIDTH_RST);
      height_reg = DATA_W'(bads_pkg::IMAGE_HEIGHT_RST);
      errors     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (col_sum[i]) col_sum[i] = 0;
      px = 0;
      py = 0;
      bx = 0;
      by = 0;
      gcol = 0;
      grow = 0;
    endfunction

    function int unsigned clamp_dim(logic [DATA_W-1:0] v);
      if (v < GRID) return GRID;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void apply_config(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == bads_pkg::REG_IMAGE_WIDTH) begin
        width_reg = data;
        clear_frame();
      end else if (idx == bads_pkg::REG_IMAGE_HEIGHT) begin
        height_reg = data;
        clear_frame();
      end
    endfunction

    function void accumulate_pixel(logic [7:0] pix);
      int unsigned w, h, bw, bh;
      cell_t c;
      w  = clamp_dim(width_reg);
      h  = clamp_dim(height_reg);
      bw = w / GRID;
      bh = h / GRID;
      if (gcol < GRID && grow < GRID) begin
        col_sum[gcol] += pix;
        if (bx == bw - 1 && by == bh - 1) begin
          c.value   = (2 * col_sum[gcol] >= bw * bh);
          c.row     = 5'(grow);
          c.col     = 5'(gcol);
          c.is_last = (grow == GRID - 1 && gcol == GRID - 1);
          pending_cells.push_back(c);
          col_sum[gcol] = 0;
        end
      end
      // advance the raster position
      if (px + 1 >= w) begin
        px = 0;
        bx = 0;
        gcol = 0;
        if (py + 1 >= h) begin
          py = 0;
          by = 0;
          grow = 0;
        end else begin
          py++;
          if (by + 1 >= bh) begin
            by = 0;
            if (grow < GRID) grow++;
          end else begin
            by++;
          end
        end
      end else begin
        px++;
        if (bx + 1 >= bw) begin
          bx = 0;
          if (gcol < GRID) gcol++;
        end else begin
          bx++;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_cell(cell_t got);
      cell_t want;
      if (pending_cells.size() == 0) begin
        report($sformatf("unexpected cell row %0d col %0d", got.row, got.col));
        return;
      end
      want = pending_cells.pop_front();
      if (got.value !== want.value)
        report($sformatf("cell (%0d,%0d) value %b, want %b", want.row, want.col, got.value,
                         want.value));
      if (got.row !== want.row)
        report($sformatf("cell row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("cell col %0d, want %0d", got.col, want.col));
      if (got.is_last !== want.is_last)
        report($sformatf("cell (%0d,%0d) last flag %b, want %b", want.row, want.col,
                         got.is_last, want.is_last));
    endtask

    function int pending();
      return pending_cells.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [INDEX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]  cfg_data_i = '0;
  logic               pixel_valid_i = 1'b0;
  logic               pixel_stall_o;
  logic [7:0]         pixel_i = '0;
  logic               cell_valid_o;
  logic               cell_stall_i = 1'b0;
  logic               cell_value_o;
  logic [4:0]         cell_row_o;
  logic [4:0]         cell_col_o;
  logic               last_cell_o;

  grid_cell_tracker grid = new();

  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  int sink_hold = 0;
  int ones_pct = 50;

  block_average_downscale_threshold_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .pixel_i       (pixel_i),
    .cell_valid_o  (cell_valid_o),
    .cell_stall_i  (cell_stall_i),
    .cell_value_o  (cell_value_o),
    .cell_row_o    (cell_row_o),
    .cell_col_o    (cell_col_o),
    .last_cell_o   (last_cell_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin : cell_monitor
    cell_t got;
    if (rst_ni === 1'b1 && cell_valid_o === 1'b1 && cell_stall_i === 1'b0) begin
      got = {cell_value_o, cell_row_o, cell_col_o, last_cell_o};
      grid.check_cell(got);
    end
  end

  // output side: random back-pressure, plus one long hold on request
  initial begin : cell_sink
    int hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = snk_idle ? $urandom_range(0, 5) : 0;
      if (sink_hold > 0) begin
        hold = sink_hold;
        sink_hold = 0;
      end
      if (hold > 0) begin
        cell_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      cell_stall_i <= 1'b0;
      do @(posedge clk_i); while (cell_valid_o !== 1'b1);
    end
  end

  function automatic logic [7:0] draw_pixel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return ($urandom_range(0, 99) < ones_pct) ? 8'd1 : 8'd0;
    if (pick == 7) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      pixel_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i       <= pix;
    do @(posedge clk_i); while (pixel_stall_o !== 1'b0);
    grid.accumulate_pixel(pix);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_pixel(draw_pixel());
  endtask

  // drop valid and hold until every outstanding cell has been transferred
  task automatic wait_drained();
    pixel_valid_i <= 1'b0;
    do @(posedge clk_i); while (grid.pending() != 0);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] data);
    wait_drained();
    // let a last pixel that produced no cell settle
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    grid.apply_config(idx, data);
  endtask

  initial begin : stimulus
    logic [7:0] extremes [8];
    int w, h, n;

    extremes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFE};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unmapped indexes leave the reset dimensions of 640 by 438 in place
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    foreach (extremes[i]) send_pixel(extremes[i]);

    // undersized dimensions clamp to one-pixel blocks
    write_reg(bads_pkg::REG_IMAGE_WIDTH, 11'd0);
    write_reg(bads_pkg::REG_IMAGE_HEIGHT, 11'd27);
    foreach (extremes[i]) send_pixel(extremes[i]);
    write_reg(REG_SPARE_2, 11'd56);
    send_random(4);

    // long output hold while input keeps coming
    write_reg(bads_pkg::REG_IMAGE_WIDTH, 11'd28);
    write_reg(bads_pkg::REG_IMAGE_HEIGHT, 11'd28);
    src_idle  = 1'b0;
    sink_hold = 150;
    send_random(120);
    src_idle = 1'b1;
    wait_drained();
    send_random(60);

    // oversized width clamps to the maximum, one row per block
    write_reg(bads_pkg::REG_IMAGE_WIDTH, 11'd2047);
    write_reg(bads_pkg::REG_IMAGE_HEIGHT, 11'd28);
    snk_idle = 1'b0;
    send_random(110);
    snk_idle = 1'b1;

    // three rows per block: results only on every third row
    write_reg(bads_pkg::REG_IMAGE_WIDTH, 11'd28);
    write_reg(bads_pkg::REG_IMAGE_HEIGHT, 11'd90);
    ones_pct = 35;
    send_random(100);

    // trailing column falls outside the grid
    write_reg(bads_pkg::REG_IMAGE_WIDTH, 11'd29);
    write_reg(bads_pkg::REG_IMAGE_HEIGHT, 11'd30);
    ones_pct = 50;
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_random(90);
    src_idle = 1'b1;
    snk_idle = 1'b1;

    repeat (2) begin
      w = $urandom_range(28, 90);
      h = $urandom_range(28, 60);
      ones_pct = $urandom_range(10, 90);
      n = $urandom_range(70, 90);
      write_reg(bads_pkg::REG_IMAGE_WIDTH, 11'(w));
      write_reg(bads_pkg::REG_IMAGE_HEIGHT, 11'(h));
      send_random(n / 2);
      // rewriting the same width restarts the frame part-way
      write_reg(bads_pkg::REG_IMAGE_WIDTH, 11'(w));
      send_random(n - n / 2);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (grid.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- block_average_downscale_threshold_top.f -----
+incdir+rtl
rtl/bads_pkg.sv
rtl/bads_queue.sv
rtl/bads_front.sv
rtl/bads_back.sv
rtl/block_average_downscale_threshold_top.sv
verif/block_average_downscale_threshold_top_tb.sv
